[hdl/tempo_line_clock_with_shuffle_unit_macros.svh]
// Assertion macros for the line clock block.
`ifndef TEMPO_LINE_CLOCK_WITH_SHUFFLE_UNIT_MACROS_SVH
`define TEMPO_LINE_CLOCK_WITH_SHUFFLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TLCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlcs: same-cycle check failed");
// Next-cycle implication.
`define TLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlcs: next-cycle check failed");
`else
`define TLCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/tlcs_pkg.sv]
package tlcs_pkg;

  localparam int DEF_MAX_LINES = 256;
  localparam int DEF_FRAC_BITS = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_SHUFFLE_DELAY = 3'd1,
    REG_START_LINE    = 3'd2,
    REG_LINE_COUNT    = 3'd3,
    REG_LOOP_ENABLE   = 3'd4
  } reg_idx_t;

  localparam logic [31:0] RST_PHASE_STEP    = 32'd715828;
  localparam logic [15:0] RST_SHUFFLE_DELAY = 16'd0;
  localparam logic [7:0]  RST_START_LINE    = 8'd0;
  localparam logic [8:0]  RST_LINE_COUNT    = 9'd32;
  localparam logic        RST_LOOP_ENABLE   = 1'b1;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] shuffle_delay;
    logic [7:0]  start_line;
    logic [8:0]  line_count;
    logic        loop_enable;
  } cfg_t;

  typedef struct packed {
    logic        line_trigger;
    logic        start_trigger;
    logic [7:0]  line_index;
    logic [15:0] alpha;
  } res_t;

  typedef struct packed {
    logic ready;
    logic skid_valid;
  } buf_status_t;

endpackage

[hdl/tlcs_cfg_regs.sv]
module tlcs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tlcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tlcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output tlcs_pkg::cfg_t                      cfg
);
  import tlcs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PHASE_STEP:    cfg_nxt.phase_step    = cfg_wdata[31:0];
        REG_SHUFFLE_DELAY: cfg_nxt.shuffle_delay = cfg_wdata[15:0];
        REG_START_LINE:    cfg_nxt.start_line    = cfg_wdata[7:0];
        REG_LINE_COUNT:    cfg_nxt.line_count    = cfg_wdata[8:0];
        REG_LOOP_ENABLE:   cfg_nxt.loop_enable   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= RST_PHASE_STEP;
      cfg_r.shuffle_delay <= RST_SHUFFLE_DELAY;
      cfg_r.start_line    <= RST_START_LINE;
      cfg_r.line_count    <= RST_LINE_COUNT;
      cfg_r.loop_enable   <= RST_LOOP_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/tlcs_core.sv]
module tlcs_core #(
  parameter int MAX_LINES = tlcs_pkg::DEF_MAX_LINES,
  parameter int FRAC_BITS = tlcs_pkg::DEF_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tlcs_pkg::cfg_t cfg,
  input  logic           advance,
  input  logic           start_pulse,
  input  logic           stop_pulse,
  output tlcs_pkg::res_t res
);
  import tlcs_pkg::*;

  // Integer part holds 0..MAX_LINES plus a sign bit.
  localparam int IW  = $clog2(MAX_LINES + 1) + 1;
  localparam int PW  = IW + FRAC_BITS;
  localparam int LCW = (IW > 9) ? IW : 9;
  localparam int SW  = (IW > 8) ? IW : 8;

  logic                 running_r, running_nxt;
  logic signed [PW-1:0] position_r, position_nxt;
  logic [7:0]           held_index_r, held_index_nxt;
  logic [15:0]          delay_count_r, delay_count_nxt;
  logic                 delay_pending_r, delay_pending_nxt;

  logic [LCW-1:0]       lc_ext;
  logic [IW-1:0]        n_lines;
  logic [SW-1:0]        sl_ext, last_ext, start_sel;
  logic [FRAC_BITS-1:0] step_f;
  logic signed [PW-1:0] step_ext;

  logic signed [PW-1:0] pos_a, pos_w, line_gap;
  logic                 run_a, pend_a, pend_b;
  logic [15:0]          cnt_a, cnt_b;
  logic [IW-1:0]        int_a, next_line, next_w;
  logic                 go, fire;
  logic [7:0]           idx;
  logic                 trig, strig;
  logic [15:0]          alpha;

  // Effective line count, clamped to 1..MAX_LINES.
  always_comb begin
    lc_ext = LCW'(cfg.line_count);
    if (lc_ext == '0) begin
      n_lines = IW'(1);
    end else if (lc_ext > LCW'(MAX_LINES)) begin
      n_lines = IW'(MAX_LINES);
    end else begin
      n_lines = IW'(lc_ext);
    end
    sl_ext    = SW'(cfg.start_line);
    last_ext  = SW'(n_lines - IW'(1));
    start_sel = (sl_ext > last_ext) ? last_ext : sl_ext;
  end

  generate
    if (FRAC_BITS >= 32) begin : g_step_wide
      assign step_f = FRAC_BITS'(cfg.phase_step) << (FRAC_BITS - 32);
    end else begin : g_step_narrow
      assign step_f = FRAC_BITS'(cfg.phase_step >> (32 - FRAC_BITS));
    end
  endgenerate

  assign step_ext = $signed({{IW{1'b0}}, step_f});

  always_comb begin
    pos_a  = position_r;
    run_a  = running_r;
    pend_a = delay_pending_r;
    cnt_a  = delay_count_r;
    if (start_pulse) begin
      pos_a = $signed({IW'(start_sel), {FRAC_BITS{1'b0}}});
      run_a = 1'b1;
    end
    // stop wins over start
    if (stop_pulse) begin
      pos_a  = '0;
      run_a  = 1'b0;
      pend_a = 1'b0;
      cnt_a  = '0;
    end

    trig  = 1'b0;
    strig = 1'b0;
    cnt_b = cnt_a;
    pend_b = pend_a;
    if (pend_a) begin
      cnt_b = cnt_a - 16'd1;
      if (cnt_b == '0) begin
        trig   = 1'b1;
        pend_b = 1'b0;
      end
    end

    alpha = pos_a[FRAC_BITS-1 -: 16];

    // ceil of the position; negative positions are above -1
    int_a     = pos_a[PW-1:FRAC_BITS];
    next_line = pos_a[PW-1] ? '0 : int_a + IW'(|pos_a[FRAC_BITS-1:0]);

    go     = 1'b1;
    pos_w  = pos_a;
    next_w = next_line;
    if (next_line >= n_lines) begin
      if (!cfg.loop_enable) begin
        go = 1'b0;
      end else begin
        pos_w  = $signed({int_a - next_line, pos_a[FRAC_BITS-1:0]});
        next_w = '0;
      end
    end

    line_gap = $signed({next_w, {FRAC_BITS{1'b0}}}) - pos_w;
    fire     = line_gap < step_ext;
    idx      = 8'(next_w);

    position_nxt      = pos_a;
    running_nxt       = run_a;
    held_index_nxt    = held_index_r;
    delay_pending_nxt = pend_b;
    delay_count_nxt   = cnt_b;
    if (run_a && (cfg.phase_step != '0) && go) begin
      if (fire) begin
        held_index_nxt = idx;
        if (idx == 8'd0) strig = 1'b1;
        if (!idx[0] || (cfg.shuffle_delay == '0)) begin
          trig = 1'b1;
        end else begin
          // a newer odd line replaces any pending delayed trigger
          delay_pending_nxt = 1'b1;
          delay_count_nxt   = cfg.shuffle_delay;
        end
      end
      position_nxt = pos_w + step_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r       <= 1'b0;
      position_r      <= '0;
      held_index_r    <= '0;
      delay_count_r   <= '0;
      delay_pending_r <= 1'b0;
    end else if (advance) begin
      running_r       <= running_nxt;
      position_r      <= position_nxt;
      held_index_r    <= held_index_nxt;
      delay_count_r   <= delay_count_nxt;
      delay_pending_r <= delay_pending_nxt;
    end
  end

  always_comb begin
    res.line_trigger  = trig;
    res.start_trigger = strig;
    res.line_index    = held_index_nxt;
    res.alpha         = alpha;
  end

endmodule

[hdl/tlcs_outbuf.sv]
module tlcs_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tlcs_pkg::res_t        push_data,
  output tlcs_pkg::buf_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlcs_pkg::res_t        out_data
);
  import tlcs_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_data_r, main_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic pop, push_ok;

  assign pop     = main_valid_r && out_ready;
  assign push_ok = push && !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push_ok) begin
        main_data_nxt = push_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push_ok) begin
      if (!main_valid_r) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign status.ready      = !skid_valid_r;
  assign status.skid_valid = skid_valid_r;
  assign out_valid         = main_valid_r;
  assign out_data          = main_data_r;

endmodule

[hdl/tempo_line_clock_with_shuffle_unit.sv]
// Sequencer line clock with shuffle. Each transfer on the input stream is one audio frame
// tick (start in in_tdata[0], stop in in_tuser[0]; stop wins) and yields exactly one result
// transfer carrying the line trigger, start trigger, held line index and the UQ0.16 fraction
// of the position taken before the tick's advance. Throughput is one tick per clock while
// the output buffer has room; a tick passes the input register, then the position update
// and result register. A two-entry output buffer keeps the input moving in an output stall
// until skid fills. Program the registers through cfg_* only while no tick is in flight.
`include "tempo_line_clock_with_shuffle_unit_macros.svh"

module tempo_line_clock_with_shuffle_unit #(
  parameter int MAX_LINES = tlcs_pkg::DEF_MAX_LINES,
  parameter int FRAC_BITS = tlcs_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] start_pulse, rest zero
  input  logic [0:0]                      in_tuser,   // [0] stop_pulse
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [7:0] line_index, [23:8] alpha
  output logic [1:0]                      out_tuser,  // [0] line_trigger, [1] start_trigger
  input  logic                            cfg_we,
  input  logic [tlcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlcs_pkg::*;

  cfg_t        cfg;
  res_t        res, out_res;
  buf_status_t buf_st;

  logic s1_valid_r, s1_start_r, s1_stop_r;
  logic advance;

  tlcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance   = s1_valid_r && buf_st.ready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_start_r <= in_tdata[0];
      s1_stop_r  <= in_tuser[0];
    end
  end

  tlcs_core #(
    .MAX_LINES (MAX_LINES),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .advance     (advance),
    .start_pulse (s1_start_r),
    .stop_pulse  (s1_stop_r),
    .res         (res)
  );

  tlcs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_data (res),
    .status    (buf_st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.alpha, out_res.line_index};
  assign out_tuser = {out_res.start_trigger, out_res.line_trigger};

  // skid entry only fills behind a held main entry
  `TLCS_ASSERT_SAME(a_skid_behind_main, clk, rst_n, buf_st.skid_valid, out_tvalid)
  // input stalls only when both the stage and the buffer are full
  `TLCS_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_tready, s1_valid_r && buf_st.skid_valid)
  // start trigger always reports line 0
  `TLCS_ASSERT_SAME(a_start_is_line0, clk, rst_n, out_tvalid && out_tuser[1],
                    out_tdata[7:0] == 8'd0)

endmodule
